// ===== rtl/core/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lkv_update and lru_key_value_cache.
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W   = IDX_W;
    localparam int OCC_W    = $clog2(ENTRIES + 1);
    localparam int CAP_W    = 5;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE     = {VAL_W{1'b1}};

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_SET = 1'b1
    } cmd_t;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [VAL_W-1:0]  val_t;

    typedef struct packed {
        logic                      hit;
        idx_t                      hit_idx;
        logic                      key_we;
        logic                      val_we;
        idx_t                      wr_idx;
        occ_t                      occ_next;
        logic [ENTRIES-1:0]        valid_next;
        rank_t [ENTRIES-1:0]       rank_next;
    } lkv_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lkv_update.sv =====
// Lookup and next-state logic: parallel key match, LRU victim pick, rank update.
// Depends on lkv_pkg.
`default_nettype none

module lkv_update
    import lkv_pkg::*;
(
    input  wire cmd_t                     cmd,
    input  wire key_t                     key,
    input  wire logic [CAP_W-1:0]         capacity,
    input  wire occ_t                     occ,
    input  wire logic [ENTRIES-1:0]       valid,
    input  wire rank_t [ENTRIES-1:0]      ranks,
    input  wire key_t [ENTRIES-1:0]       keys,
    output lkv_ctrl_t                     ctrl
);

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] oldest;
    logic [ENTRIES-1:0] evict_mask;
    logic [ENTRIES-1:0] free_mask;
    logic [ENTRIES-1:0] remain;
    logic               hit;
    idx_t               hit_idx;
    idx_t               evict_idx;
    idx_t               free_idx;
    rank_t              hit_rank;
    rank_t              last_rank;
    logic [31:0]        eff_cap;
    logic               full;

    always_comb begin
        if (capacity == '0) begin
            eff_cap = 32'd1;
        end else if (32'(capacity) > 32'(ENTRIES)) begin
            eff_cap = 32'(ENTRIES);
        end else begin
            eff_cap = 32'(capacity);
        end
    end

    assign full      = 32'(occ) >= eff_cap;
    assign last_rank = RANK_W'(occ - OCC_W'(1));

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = valid[i] && (keys[i] == key);
            oldest[i] = valid[i] && (ranks[i] == last_rank);
            if (match[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit_rank = ranks[hit_idx];

    always_comb begin
        evict_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (oldest[i]) begin
                evict_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        evict_mask = '0;
        if (full && (oldest != '0)) begin
            evict_mask[evict_idx] = 1'b1;
        end
    end

    assign remain    = valid & ~evict_mask;
    assign free_mask = ~remain;

    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (free_mask[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        ctrl            = '0;
        ctrl.hit        = hit;
        ctrl.hit_idx    = hit_idx;
        ctrl.occ_next   = occ;
        ctrl.valid_next = valid;
        ctrl.rank_next  = ranks;
        ctrl.wr_idx     = hit_idx;
        if (hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == hit_idx) begin
                    ctrl.rank_next[i] = '0;
                end else if (valid[i] && (ranks[i] < hit_rank)) begin
                    ctrl.rank_next[i] = ranks[i] + RANK_W'(1);
                end
            end
            ctrl.val_we = (cmd == CMD_SET);
        end else if (cmd == CMD_SET) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (remain[i]) begin
                    ctrl.rank_next[i] = ranks[i] + RANK_W'(1);
                end else begin
                    ctrl.rank_next[i] = '0;
                end
            end
            ctrl.valid_next           = remain;
            ctrl.valid_next[free_idx] = 1'b1;
            ctrl.rank_next[free_idx]  = '0;
            ctrl.wr_idx               = free_idx;
            ctrl.key_we               = 1'b1;
            ctrl.val_we               = 1'b1;
            ctrl.occ_next             = (evict_mask != '0) ? occ : occ + OCC_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg and lkv_update.
`default_nettype none

// One get or set per beat, one result beat per input beat. Each beat is
// decoded in the cycle it is accepted: all 16 stored keys are compared in
// parallel and the keys, values, valid bits, recency ranks and occupancy
// are updated at that edge, so the next beat sees the new state without
// any wait. The result is registered at acceptance in an output register
// on the master side; the slave side keeps taking beats as long as that
// register is empty or being drained, giving one beat per cycle. A get
// miss and every set return -1; found reports whether the key was present.
// The capacity register (1..16, zero acts as 1, above 16 acts as 16) must be
// written on the cfg channel only while idle; the block does not enforce it.
module lru_key_value_cache
    import lkv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CAP_W-1:0]  cfg_data,     // capacity
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [63:0]       s_tdata,      // [31:0] key, [63:32] value
    input  wire logic              s_tuser,      // command
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,      // read_value
    output logic                   m_tuser       // found
);

    logic [CAP_W-1:0]     capacity_reg;
    occ_t                 occ_reg;
    logic [ENTRIES-1:0]   valid_reg;
    rank_t [ENTRIES-1:0]  rank_reg;
    key_t [ENTRIES-1:0]   key_reg;
    val_t [ENTRIES-1:0]   val_reg;
    logic                 out_valid_reg;
    logic                 out_found_reg;
    val_t                 out_value_reg;
    val_t                 out_value_next;
    lkv_ctrl_t            ctrl;
    cmd_t                 cmd;
    logic                 accept;

    assign cmd       = cmd_t'(s_tuser);
    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    lkv_update u_update (
        .cmd      (cmd),
        .key      (s_tdata[31:0]),
        .capacity (capacity_reg),
        .occ      (occ_reg),
        .valid    (valid_reg),
        .ranks    (rank_reg),
        .keys     (key_reg),
        .ctrl     (ctrl)
    );

    always_comb begin
        if (ctrl.hit && (cmd == CMD_GET)) begin
            out_value_next = val_reg[ctrl.hit_idx];
        end else begin
            out_value_next = MISS_VALUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= CAPACITY_RESET;
            occ_reg       <= '0;
            valid_reg     <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (accept) begin
                occ_reg       <= ctrl.occ_next;
                valid_reg     <= ctrl.valid_next;
                rank_reg      <= ctrl.rank_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_found_reg <= ctrl.hit;
            out_value_reg <= out_value_next;
            if (ctrl.key_we) begin
                key_reg[ctrl.wr_idx] <= s_tdata[31:0];
            end
            if (ctrl.val_we) begin
                val_reg[ctrl.wr_idx] <= s_tdata[63:32];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_found_reg;

endmodule

`default_nettype wire
